/* src/sparse_triplet_matvec_top_macros.svh */
// Assertion shorthands for the sparse triplet matvec block.
`ifndef SPARSE_TRIPLET_MATVEC_TOP_MACROS_SVH
`define SPARSE_TRIPLET_MATVEC_TOP_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define STM_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define STM_ASSERT_RAW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/stm_pkg.sv */
package stm_pkg;

    localparam int DEF_VECTOR_DEPTH = 1024;
    localparam int QUEUE_DEPTH      = 2;
    localparam int IDX_W            = 10;
    localparam int CFG_IDX_W        = 3;

    localparam logic [63:0] ALPHA_RESET = 64'h3FF0_0000_0000_0000;

    // input item kinds
    localparam logic [1:0] KIND_LOAD_X = 2'd0;
    localparam logic [1:0] KIND_LOAD_Y = 2'd1;
    localparam logic [1:0] KIND_TRIP   = 2'd2;
    localparam logic [1:0] KIND_READ_Y = 2'd3;

    // product modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_TRANS = 2'd1;
    localparam logic [1:0] MODE_SYM   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd4;

    // operations handed from front to back
    localparam logic [2:0] OP_LOAD_X = 3'd0;
    localparam logic [2:0] OP_LOAD_Y = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_READ_Y = 3'd3;
    localparam logic [2:0] OP_ERROR  = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [63:0]      value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [63:0]      y_value;
        logic             range_error;
    } out_item_t;

    typedef struct packed {
        logic [2:0]       code;
        logic [IDX_W-1:0] tgt;
        logic [IDX_W-1:0] src;
        logic [63:0]      value;
        logic             mirror;
    } op_t;

endpackage

/* src/sparse_triplet_matvec_top.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_item_t (kind, index, row, col, value)
// out       output     out_valid/out_ready  out_item_t (out_index, y_value, range_error)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// Front end classifies each item in its accept cycle and pushes it into a two-entry queue.
// Back end runs one queued item at a time: x loads and range errors finish when popped,
// reads return the registered y store word, a y load is one double multiply, an
// update is two multiplies and an add, repeated with indices swapped for a mirrored
// symmetric update; each double op normalizes subnormal or cancelled results.
// Reset clears control state only; vector stores hold garbage until loaded.
module sparse_triplet_matvec_top
    import stm_pkg::*;
#(
    parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [63:0] alpha_reg, beta_reg;
    logic [1:0]  mode_reg;
    logic [10:0] row_count_reg, col_count_reg;

    op_t  front_op, head_op;
    logic q_full, q_push, head_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RESET;
            beta_reg      <= '0;
            mode_reg      <= MODE_PLAIN;
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHA: alpha_reg     <= cfg_data;
                REG_BETA:  beta_reg      <= cfg_data;
                REG_MODE:  mode_reg      <= cfg_data[1:0];
                REG_ROWS:  row_count_reg <= cfg_data[10:0];
                REG_COLS:  col_count_reg <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    stm_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .item      (in_data),
        .mode      (mode_reg),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .op        (front_op)
    );

    stm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (front_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    stm_back #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (q_pop),
        .alpha      (alpha_reg),
        .beta       (beta_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

/* src/stm_queue.sv */
module stm_queue
    import stm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head_op
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    op_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* src/stm_front.sv */
module stm_front
    import stm_pkg::*;
#(
    parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH
)
(
    input  in_item_t    item,
    input  logic [1:0]  mode,
    input  logic [10:0] row_count,
    input  logic [10:0] col_count,
    output op_t         op
);

    localparam int LW = $clog2(VECTOR_DEPTH + 1);

    logic [LW-1:0] rows_used, cols_used, min_used;
    logic [LW-1:0] x_len, y_len, row_lim, col_lim;

    always_comb
    begin
        // saturate lengths at the store depth
        rows_used = (32'(row_count) > 32'(VECTOR_DEPTH)) ? LW'(VECTOR_DEPTH) : LW'(row_count);
        cols_used = (32'(col_count) > 32'(VECTOR_DEPTH)) ? LW'(VECTOR_DEPTH) : LW'(col_count);
        min_used  = (rows_used < cols_used) ? rows_used : cols_used;

        case (mode)
            MODE_TRANS:
            begin
                x_len = rows_used;
                y_len = cols_used;
            end
            MODE_SYM:
            begin
                x_len = min_used;
                y_len = min_used;
            end
            default:
            begin
                x_len = cols_used;
                y_len = rows_used;
            end
        endcase

        row_lim = (mode == MODE_TRANS) ? x_len : y_len;
        col_lim = (mode == MODE_TRANS) ? y_len : x_len;

        op        = '0;
        op.value  = item.value;
        op.tgt    = item.index;
        op.src    = item.index;

        case (item.kind)
            KIND_LOAD_X:
            begin
                op.code = (32'(item.index) >= 32'(x_len)) ? OP_ERROR : OP_LOAD_X;
            end
            KIND_LOAD_Y:
            begin
                op.code = (32'(item.index) >= 32'(y_len)) ? OP_ERROR : OP_LOAD_Y;
            end
            KIND_READ_Y:
            begin
                op.code = (32'(item.index) >= 32'(y_len)) ? OP_ERROR : OP_READ_Y;
            end
            default:
            begin
                if (32'(item.row) >= 32'(row_lim))
                begin
                    op.code = OP_ERROR;
                    op.tgt  = item.row;
                end
                else if (32'(item.col) >= 32'(col_lim))
                begin
                    op.code = OP_ERROR;
                    op.tgt  = item.col;
                end
                else if (mode == MODE_TRANS)
                begin
                    op.code = OP_UPDATE;
                    op.tgt  = item.col;
                    op.src  = item.row;
                end
                else
                begin
                    op.code   = OP_UPDATE;
                    op.tgt    = item.row;
                    op.src    = item.col;
                    op.mirror = (mode == MODE_SYM) && (item.row != item.col);
                end
            end
        endcase
    end

endmodule

/* src/stm_fpu.sv */
module stm_fpu
    import stm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        op_add,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    localparam logic [2:0] F_IDLE   = 3'd0;
    localparam logic [2:0] F_PREP   = 3'd1;
    localparam logic [2:0] F_MUL    = 3'd2;
    localparam logic [2:0] F_ADD    = 3'd3;
    localparam logic [2:0] F_NORM   = 3'd4;
    localparam logic [2:0] F_DENORM = 3'd5;
    localparam logic [2:0] F_ROUND  = 3'd6;
    localparam logic [2:0] F_DONE   = 3'd7;

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    logic [2:0]          state_reg, state_next;
    logic [63:0]         a_reg, a_next, b_reg, b_next;
    logic                add_reg, add_next;
    logic                sign_reg, sign_next;
    logic                zs_reg, zs_next;
    logic                sub_reg, sub_next;
    logic signed [13:0]  exp_reg, exp_next;
    logic [105:0]        man_reg, man_next;
    logic [105:0]        aux_reg, aux_next;
    logic [52:0]         ma_reg, ma_next, mb_reg, mb_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [63:0]         res_reg, res_next;

    logic [10:0]  ea, eb, ea_e, eb_e;
    logic [51:0]  fa, fb;
    logic         sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [52:0]  ma, mb;
    logic         a_ge;
    logic [10:0]  lg_exp, sm_exp, add_d;
    logic [52:0]  lg_man, sm_man;
    logic [105:0] sm_wide, sm_mask, aligned;
    logic [26:0]  pp_a, pp_b;
    logic [53:0]  pp;
    logic [6:0]   pp_sh;
    logic [105:0] sum;
    logic [13:0]  dn_sh;
    logic [105:0] dn_mask;
    logic [53:0]  m54;
    logic         rnd_up;
    logic signed [13:0] fld;
    logic [51:0]  frac;

    assign done   = (state_reg == F_DONE);
    assign result = res_reg;

    always_comb
    begin
        sa = a_reg[63];
        sb = b_reg[63];
        ea = a_reg[62:52];
        eb = b_reg[62:52];
        fa = a_reg[51:0];
        fb = b_reg[51:0];
        a_nan  = (&ea) && (|fa);
        b_nan  = (&eb) && (|fb);
        a_inf  = (&ea) && !(|fa);
        b_inf  = (&eb) && !(|fb);
        a_zero = (ea == '0) && (fa == '0);
        b_zero = (eb == '0) && (fb == '0);
        ma   = {|ea, fa};
        mb   = {|eb, fb};
        ea_e = (ea == '0) ? 11'd1 : ea;
        eb_e = (eb == '0) ? 11'd1 : eb;

        // operand alignment for add
        a_ge   = (a_reg[62:0] >= b_reg[62:0]);
        lg_exp = a_ge ? ea_e : eb_e;
        sm_exp = a_ge ? eb_e : ea_e;
        lg_man = a_ge ? ma : mb;
        sm_man = a_ge ? mb : ma;
        add_d  = lg_exp - sm_exp;
        sm_wide = {1'b0, sm_man, 52'b0};
        sm_mask = ~({106{1'b1}} << add_d);
        if (add_d >= 11'd106)
        begin
            aligned = {105'b0, |sm_man};
        end
        else
        begin
            aligned = (sm_wide >> add_d) | {105'b0, |(sm_wide & sm_mask)};
        end

        // one 27x27 partial product per cycle
        pp_a = cnt_reg[0] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        pp_b = cnt_reg[1] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp   = pp_a * pp_b;
        case (cnt_reg)
            2'd0:    pp_sh = 7'd0;
            2'd3:    pp_sh = 7'd54;
            default: pp_sh = 7'd27;
        endcase

        sum = sub_reg ? (man_reg - aux_reg) : (man_reg + aux_reg);

        dn_sh   = 14'(14'sd1 - exp_reg);
        dn_mask = ~({106{1'b1}} << dn_sh);

        rnd_up = man_reg[51] && ((|man_reg[50:0]) || man_reg[52]);
        m54    = {1'b0, man_reg[104:52]} + 54'(rnd_up);
        if (m54[53])
        begin
            fld  = exp_reg + 14'sd1;
            frac = '0;
        end
        else
        begin
            fld  = m54[52] ? exp_reg : 14'sd0;
            frac = m54[51:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        add_next   = add_reg;
        sign_next  = sign_reg;
        zs_next    = zs_reg;
        sub_next   = sub_reg;
        exp_next   = exp_reg;
        man_next   = man_reg;
        aux_next   = aux_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;

        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    b_next     = b;
                    add_next   = op_add;
                    state_next = F_PREP;
                end
            end
            F_PREP:
            begin
                if (a_nan)
                begin
                    res_next   = a_reg | 64'h0008_0000_0000_0000;
                    state_next = F_DONE;
                end
                else if (b_nan)
                begin
                    res_next   = b_reg | 64'h0008_0000_0000_0000;
                    state_next = F_DONE;
                end
                else if (!add_reg && (a_inf || b_inf))
                begin
                    res_next   = (a_zero || b_zero) ? DEFAULT_NAN
                                                    : {sa ^ sb, 11'h7FF, 52'b0};
                    state_next = F_DONE;
                end
                else if (add_reg && a_inf && b_inf && (sa != sb))
                begin
                    res_next   = DEFAULT_NAN;
                    state_next = F_DONE;
                end
                else if (add_reg && (a_inf || b_inf))
                begin
                    res_next   = a_inf ? a_reg : b_reg;
                    state_next = F_DONE;
                end
                else if (!add_reg)
                begin
                    sign_next  = sa ^ sb;
                    exp_next   = $signed({3'b0, ea_e}) + $signed({3'b0, eb_e}) - 14'sd1023;
                    ma_next    = ma;
                    mb_next    = mb;
                    man_next   = '0;
                    cnt_next   = '0;
                    state_next = F_MUL;
                end
                else
                begin
                    sign_next  = a_ge ? sa : sb;
                    zs_next    = sa & sb;
                    sub_next   = sa ^ sb;
                    exp_next   = $signed({3'b0, lg_exp});
                    man_next   = {1'b0, lg_man, 52'b0};
                    aux_next   = aligned;
                    state_next = F_ADD;
                end
            end
            F_MUL:
            begin
                man_next = man_reg + (106'(pp) << pp_sh);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = F_NORM;
                end
            end
            F_ADD:
            begin
                man_next   = sum;
                // exact zero: negative only when both addends were negative
                sign_next  = (sum == '0) ? zs_reg : sign_reg;
                state_next = F_NORM;
            end
            F_NORM:
            begin
                if (man_reg[105])
                begin
                    man_next = {1'b0, man_reg[105:2], man_reg[1] | man_reg[0]};
                    exp_next = exp_reg + 14'sd1;
                end
                else if (!man_reg[104] && (man_reg != '0) && (exp_reg > 14'sd1))
                begin
                    man_next = {man_reg[104:0], 1'b0};
                    exp_next = exp_reg - 14'sd1;
                end
                else
                begin
                    state_next = F_DENORM;
                end
            end
            F_DENORM:
            begin
                if (exp_reg < 14'sd1)
                begin
                    if (dn_sh >= 14'd106)
                    begin
                        man_next = {105'b0, |man_reg};
                    end
                    else
                    begin
                        man_next = (man_reg >> dn_sh) | {105'b0, |(man_reg & dn_mask)};
                    end
                    exp_next = 14'sd1;
                end
                state_next = F_ROUND;
            end
            F_ROUND:
            begin
                if (fld >= 14'sd2047)
                begin
                    res_next = {sign_reg, 11'h7FF, 52'b0};
                end
                else
                begin
                    res_next = {sign_reg, fld[10:0], frac};
                end
                state_next = F_DONE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        add_reg  <= add_next;
        sign_reg <= sign_next;
        zs_reg   <= zs_next;
        sub_reg  <= sub_next;
        exp_reg  <= exp_next;
        man_reg  <= man_next;
        aux_reg  <= aux_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

endmodule

/* src/stm_back.sv */
module stm_back
    import stm_pkg::*;
#(
    parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  op_t         head_op,
    output logic        pop,
    input  logic [63:0] alpha,
    input  logic [63:0] beta,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    localparam int AW = $clog2(VECTOR_DEPTH);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_AX   = 4'd1;
    localparam logic [3:0] B_AXW  = 4'd2;
    localparam logic [3:0] B_T    = 4'd3;
    localparam logic [3:0] B_TW   = 4'd4;
    localparam logic [3:0] B_S    = 4'd5;
    localparam logic [3:0] B_SW   = 4'd6;
    localparam logic [3:0] B_RY   = 4'd7;
    localparam logic [3:0] B_LYW  = 4'd8;

    logic [63:0] x_mem [VECTOR_DEPTH];
    logic [63:0] y_mem [VECTOR_DEPTH];

    logic [3:0]  state_reg, state_next;
    op_t         cur_reg, cur_next;
    logic [63:0] y_old_reg, y_old_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic [AW-1:0] x_raddr, y_raddr, y_waddr;
    logic [63:0]   x_rdata, y_rdata, y_wdata;
    logic          x_we, y_we;

    logic          fpu_start, fpu_add, fpu_done;
    logic [63:0]   fpu_a, fpu_b, fres;
    logic          out_op;

    stm_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fpu_start),
        .op_add (fpu_add),
        .a      (fpu_a),
        .b      (fpu_b),
        .done   (fpu_done),
        .result (fres)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_op = (head_op.code == OP_ERROR) || (head_op.code == OP_READ_Y);
        // hold ops that report until the output register is free
        pop    = (state_reg == B_IDLE) && head_valid && (!out_op || !out_valid_reg);

        x_raddr = (state_reg == B_SW) ? AW'(cur_reg.tgt) : AW'(head_op.src);
        y_raddr = (state_reg == B_SW) ? AW'(cur_reg.src) : AW'(head_op.tgt);

        x_we    = pop && (head_op.code == OP_LOAD_X);
        y_we    = fpu_done && ((state_reg == B_SW) || (state_reg == B_LYW));
        y_waddr = AW'(cur_reg.tgt);
        y_wdata = fres;

        fpu_start = 1'b0;
        fpu_add   = 1'b0;
        fpu_a     = head_op.value;
        fpu_b     = beta;

        state_next     = state_reg;
        cur_next       = cur_reg;
        y_old_next     = y_old_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    cur_next = head_op;
                    case (head_op.code)
                        OP_ERROR:
                        begin
                            out_valid_next            = 1'b1;
                            out_data_next.out_index   = head_op.tgt;
                            out_data_next.y_value     = '0;
                            out_data_next.range_error = 1'b1;
                        end
                        OP_LOAD_Y:
                        begin
                            fpu_start  = 1'b1;
                            state_next = B_LYW;
                        end
                        OP_READ_Y:
                        begin
                            state_next = B_RY;
                        end
                        OP_UPDATE:
                        begin
                            state_next = B_AX;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_RY:
            begin
                out_valid_next            = 1'b1;
                out_data_next.out_index   = cur_reg.tgt;
                out_data_next.y_value     = y_rdata;
                out_data_next.range_error = 1'b0;
                state_next                = B_IDLE;
            end
            B_LYW:
            begin
                if (fpu_done)
                begin
                    state_next = B_IDLE;
                end
            end
            B_AX:
            begin
                y_old_next = y_rdata;
                fpu_start  = 1'b1;
                fpu_a      = alpha;
                fpu_b      = x_rdata;
                state_next = B_AXW;
            end
            B_AXW:
            begin
                if (fpu_done)
                begin
                    state_next = B_T;
                end
            end
            B_T:
            begin
                fpu_start  = 1'b1;
                fpu_a      = fres;
                fpu_b      = cur_reg.value;
                state_next = B_TW;
            end
            B_TW:
            begin
                if (fpu_done)
                begin
                    state_next = B_S;
                end
            end
            B_S:
            begin
                fpu_start  = 1'b1;
                fpu_add    = 1'b1;
                fpu_a      = y_old_reg;
                fpu_b      = fres;
                state_next = B_SW;
            end
            B_SW:
            begin
                if (fpu_done)
                begin
                    if (cur_reg.mirror)
                    begin
                        // mirrored update: swap target and source, run again
                        cur_next.tgt    = cur_reg.src;
                        cur_next.src    = cur_reg.tgt;
                        cur_next.mirror = 1'b0;
                        state_next      = B_AX;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        y_old_reg    <= y_old_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[AW'(head_op.tgt)] <= head_op.value;
        end
        x_rdata <= x_mem[x_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
        begin
            y_mem[y_waddr] <= y_wdata;
        end
        y_rdata <= y_mem[y_raddr];
    end

endmodule

/* src/stm_checker.sv */
`include "sparse_triplet_matvec_top_macros.svh"

module stm_checker
    import stm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    `STM_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
    `STM_ASSERT_CLK(a_err_zero, out_valid && out_data.range_error |-> out_data.y_value == 64'd0, "error result carries a value")
    `STM_ASSERT_CLK(a_full_on_push, $fell(in_ready) |-> $past(in_valid), "queue filled without an accepted item")
    `STM_ASSERT_RAW(a_reset_quiet, $rose(rst_n) |-> !out_valid, "result present out of reset")

endmodule

bind sparse_triplet_matvec_top stm_checker u_stm_checker (.*);

/* tb/sv/sparse_triplet_matvec_top_tb.sv */
`timescale 1ns / 1ps

module sparse_triplet_matvec_top_tb;
    import stm_pkg::*;

    localparam int DEPTH = DEF_VECTOR_DEPTH;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES = 2500;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    sparse_triplet_matvec_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's vectors and registers
    real         x_vec [DEPTH];
    real         y_vec [DEPTH];
    logic [63:0] alpha_reg;
    logic [63:0] beta_reg;
    logic [1:0]  mode_reg;
    logic [10:0] rows_reg;
    logic [10:0] cols_reg;

    in_item_t  pending_items [$];
    out_item_t expected_reads [$];

    int  errors;
    int  items_in;
    int  results_out;
    int  range_errors;
    int  in_gap;
    int  out_gap;
    int  stall_rate;
    int  stall_cycles;
    bit  no_idle;
    bit  in_took;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic void vec_lengths(output int xlen, output int ylen);
        int r;
        int c;
        r = (rows_reg > DEPTH) ? DEPTH : rows_reg;
        c = (cols_reg > DEPTH) ? DEPTH : cols_reg;
        if (mode_reg == MODE_TRANS)
        begin
            xlen = r;
            ylen = c;
        end
        else if (mode_reg == MODE_SYM)
        begin
            xlen = (r < c) ? r : c;
            ylen = xlen;
        end
        else
        begin
            xlen = c;
            ylen = r;
        end
    endfunction

    function automatic void madd_into_y(int tgt, int src, real v);
        real ax;
        real prod;
        ax = $bitstoreal(alpha_reg) * x_vec[src];
        prod = ax * v;
        y_vec[tgt] = y_vec[tgt] + prod;
    endfunction

    function automatic out_item_t range_fail(int idx);
        out_item_t r;
        r.out_index = idx[IDX_W-1:0];
        r.y_value = '0;
        r.range_error = 1'b1;
        return r;
    endfunction

    // advance the shadow by one accepted item, queue any result it owes
    function automatic void apply_item(in_item_t it);
        int xlen;
        int ylen;
        int rlim;
        int clim;
        out_item_t r;
        vec_lengths(xlen, ylen);
        case (it.kind)
            KIND_LOAD_X:
                if (it.index >= xlen)
                    expected_reads.push_back(range_fail(it.index));
                else
                    x_vec[it.index] = $bitstoreal(it.value);
            KIND_LOAD_Y:
                if (it.index >= ylen)
                    expected_reads.push_back(range_fail(it.index));
                else
                    y_vec[it.index] = $bitstoreal(it.value) * $bitstoreal(beta_reg);
            KIND_READ_Y:
                if (it.index >= ylen)
                    expected_reads.push_back(range_fail(it.index));
                else
                begin
                    r.out_index = it.index;
                    r.y_value = $realtobits(y_vec[it.index]);
                    r.range_error = 1'b0;
                    expected_reads.push_back(r);
                end
            default:
            begin
                rlim = (mode_reg == MODE_TRANS) ? xlen : ylen;
                clim = (mode_reg == MODE_TRANS) ? ylen : xlen;
                if (it.row >= rlim)
                    expected_reads.push_back(range_fail(it.row));
                else if (it.col >= clim)
                    expected_reads.push_back(range_fail(it.col));
                else if (mode_reg == MODE_TRANS)
                    madd_into_y(it.col, it.row, $bitstoreal(it.value));
                else
                begin
                    madd_into_y(it.row, it.col, $bitstoreal(it.value));
                    if (mode_reg == MODE_SYM && it.row != it.col)
                        madd_into_y(it.col, it.row, $bitstoreal(it.value));
                end
            end
        endcase
    endfunction

    // input driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap = 0;
        end
        else if (in_valid && !in_took)
        begin
            // hold until taken
        end
        else if (in_gap > 0)
        begin
            in_gap--;
            in_valid <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < stall_rate)
        begin
            in_gap = $urandom_range(0, 10);
            in_valid <= 1'b0;
        end
        else if (pending_items.size() > 0)
        begin
            in_data <= pending_items.pop_front();
            in_valid <= 1'b1;
        end
        else
            in_valid <= 1'b0;
    end

    // output backpressure
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < stall_rate)
        begin
            out_gap = $urandom_range(0, 10);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        in_took = rst_n && in_valid && in_ready;
        if (in_took)
        begin
            items_in++;
            apply_item(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_out++;
            if (out_data.range_error)
                range_errors++;
            if (expected_reads.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, actual %h", $time, out_data);
            end
            else
            begin
                out_item_t e;
                e = expected_reads.pop_front();
                if (e.out_index !== out_data.out_index)
                begin
                    errors++;
                    $display("%0t: out_index expected %0d actual %0d", $time,
                             e.out_index, out_data.out_index);
                end
                if (e.y_value !== out_data.y_value)
                begin
                    errors++;
                    $display("%0t: y_value expected %h actual %h", $time,
                             e.y_value, out_data.y_value);
                end
                if (e.range_error !== out_data.range_error)
                begin
                    errors++;
                    $display("%0t: range_error expected %b actual %b", $time,
                             e.range_error, out_data.range_error);
                end
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic in_item_t make_item(logic [1:0] k, int idx, int r, int c,
                                           logic [63:0] v);
        in_item_t it;
        it.kind = k;
        it.index = idx[IDX_W-1:0];
        it.row = r[IDX_W-1:0];
        it.col = c[IDX_W-1:0];
        it.value = v;
        return it;
    endfunction

    // finite double of moderate size, occasionally a signed zero
    function automatic logic [63:0] rand_double();
        logic [63:0] b;
        b = {$urandom, $urandom};
        if ($urandom_range(0, 19) == 0)
            b[62:0] = '0;
        else
            b[62:52] = 11'd1023 - 11'd12 + 11'($urandom_range(0, 24));
        return b;
    endfunction

    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid && expected_reads.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_ALPHA: alpha_reg = data;
            REG_BETA:  beta_reg = data;
            REG_MODE:  mode_reg = data[1:0];
            REG_ROWS:  rows_reg = data[10:0];
            default:   cols_reg = data[10:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [63:0] a, logic [63:0] b, logic [1:0] m,
                         int r, int c);
        drain();
        write_reg(REG_ALPHA, a);
        write_reg(REG_BETA, b);
        write_reg(REG_MODE, {62'd0, m});
        write_reg(REG_ROWS, 64'(r));
        write_reg(REG_COLS, 64'(c));
    endtask

    // index list within a length: both ends plus a few random entries
    task automatic pick_live(int len, ref int live [$]);
        live = {};
        if (len == 0)
            return;
        live.push_back(0);
        live.push_back(len - 1);
        repeat (6) live.push_back($urandom_range(0, len - 1));
    endtask

    task automatic run_phase(logic [63:0] a, logic [63:0] b, logic [1:0] m,
                             int r, int c, int count);
        int xlen;
        int ylen;
        int lx [$];
        int ly [$];
        int sel;
        int s;
        int t;
        int bad;
        setup(a, b, m, r, c);
        stall_rate = $urandom_range(0, 2) * 10;
        vec_lengths(xlen, ylen);
        pick_live(xlen, lx);
        if (m == MODE_SYM)
            ly = lx;
        else
            pick_live(ylen, ly);
        foreach (lx[i])
            pending_items.push_back(make_item(KIND_LOAD_X, lx[i], $urandom, $urandom,
                                              rand_double()));
        foreach (ly[i])
            pending_items.push_back(make_item(KIND_LOAD_Y, ly[i], $urandom, $urandom,
                                              rand_double()));
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 88 && lx.size() > 0 && ly.size() > 0)
            begin
                s = lx[$urandom_range(0, lx.size() - 1)];
                t = ly[$urandom_range(0, ly.size() - 1)];
                if (m == MODE_SYM)
                    s = lx[$urandom_range(0, lx.size() - 1)];
                if (sel < 55)
                begin
                    if (m == MODE_TRANS)
                        pending_items.push_back(make_item(KIND_TRIP, $urandom, s, t,
                                                          rand_double()));
                    else
                        pending_items.push_back(make_item(KIND_TRIP, $urandom, t, s,
                                                          rand_double()));
                end
                else if (sel < 72)
                    pending_items.push_back(make_item(KIND_READ_Y, t, $urandom, $urandom,
                                                      {$urandom, $urandom}));
                else if (sel < 80)
                    pending_items.push_back(make_item(KIND_LOAD_Y, t, $urandom, $urandom,
                                                      rand_double()));
                else
                    pending_items.push_back(make_item(KIND_LOAD_X, s, $urandom, $urandom,
                                                      rand_double()));
            end
            else
            begin
                // out of range item; nothing is stored, so any bits go
                bad = $urandom_range((ylen < xlen ? ylen : xlen), DEPTH - 1);
                if (bad < DEPTH && (ylen < DEPTH || xlen < DEPTH))
                    pending_items.push_back(make_item(2'($urandom_range(0, 3)),
                                                      ylen < DEPTH && xlen < DEPTH ?
                                                      $urandom_range(
                                                      (xlen > ylen ? xlen : ylen),
                                                      DEPTH - 1) : bad,
                                                      bad, bad, {$urandom, $urandom}));
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ALPHA;
        cfg_data = '0;
        alpha_reg = ALPHA_RESET;
        beta_reg = '0;
        mode_reg = MODE_PLAIN;
        rows_reg = '0;
        cols_reg = '0;
        errors = 0;
        items_in = 0;
        results_out = 0;
        range_errors = 0;
        stall_rate = 10;
        no_idle = 1'b0;
        in_took = 1'b0;
        stall_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // after reset all lengths are zero: every access is rejected
        pending_items.push_back(make_item(KIND_READ_Y, 0, 0, 0, '0));
        pending_items.push_back(make_item(KIND_TRIP, 0, 0, 0, '1));

        setup(ALPHA_RESET, 64'h3FF0_0000_0000_0000, MODE_PLAIN, 4, 4);
        pending_items.push_back(make_item(KIND_LOAD_X, 0, 0, 0, 64'h7FF0_0000_0000_0000));
        pending_items.push_back(make_item(KIND_LOAD_X, 0, 1023, 1023,
                                          64'h3FF8_0000_0000_0000));
        pending_items.push_back(make_item(KIND_LOAD_X, 1, 0, 0, 64'h0000_0000_0000_0001));
        pending_items.push_back(make_item(KIND_LOAD_X, 3, 0, 0, 64'hC000_0000_0000_0000));
        pending_items.push_back(make_item(KIND_LOAD_Y, 0, 0, 0, 64'h4000_0000_0000_0000));
        pending_items.push_back(make_item(KIND_LOAD_Y, 2, 0, 0, 64'hFFF0_0000_0000_0000));
        pending_items.push_back(make_item(KIND_READ_Y, 2, 0, 0, '0));
        pending_items.push_back(make_item(KIND_LOAD_Y, 2, 0, 0, 64'h8000_0000_0000_0000));
        pending_items.push_back(make_item(KIND_LOAD_Y, 3, 0, 0, 64'h000F_FFFF_FFFF_FFFF));
        pending_items.push_back(make_item(KIND_TRIP, 0, 0, 0, 64'h3FE0_0000_0000_0000));
        pending_items.push_back(make_item(KIND_TRIP, 0, 3, 1, 64'h4340_0000_0000_0000));
        pending_items.push_back(make_item(KIND_TRIP, 0, 2, 3, 64'hBFF0_0000_0000_0000));
        pending_items.push_back(make_item(KIND_TRIP, 0, 4, 0, '1));
        pending_items.push_back(make_item(KIND_TRIP, 0, 0, 5, '1));
        pending_items.push_back(make_item(KIND_TRIP, 0, 1023, 1023, '1));
        pending_items.push_back(make_item(KIND_LOAD_X, 1023, 0, 0, '1));
        pending_items.push_back(make_item(KIND_LOAD_Y, 4, 0, 0, '1));
        pending_items.push_back(make_item(KIND_READ_Y, 1023, 0, 0, '1));
        pending_items.push_back(make_item(KIND_READ_Y, 0, 0, 0, '0));
        pending_items.push_back(make_item(KIND_READ_Y, 2, 0, 0, '0));
        pending_items.push_back(make_item(KIND_READ_Y, 3, 0, 0, '0));

        run_phase(64'h4008_0000_0000_0000, 64'hBFE0_0000_0000_0000, MODE_PLAIN, 9, 5, 110);
        run_phase(64'h0010_0000_0000_0000, 64'h3FF0_0000_0000_0000, MODE_TRANS, 3, 12, 110);
        run_phase(64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000, MODE_SYM, 7, 10, 110);
        run_phase(64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 2'd3, 1024, 2047, 90);
        run_phase(ALPHA_RESET, 64'h3FF0_0000_0000_0000, MODE_SYM, 2047, 1024, 90);
        run_phase(64'h3FD0_0000_0000_0000, 64'h7FE0_0000_0000_0000, MODE_TRANS, 1, 0, 40);
        drain();
        no_idle = 1'b1;
        run_phase(64'h4010_0000_0000_0000, 64'h3FF8_0000_0000_0000, MODE_PLAIN, 6, 6, 110);
        drain();

        $display("%0d items sent over plain, transposed, symmetric and unused modes",
                 items_in);
        $display("%0d results checked, %0d of them range errors", results_out,
                 range_errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/stm_pkg.sv
src/stm_queue.sv
src/stm_front.sv
src/stm_fpu.sv
src/stm_back.sv
src/sparse_triplet_matvec_top.sv
src/stm_checker.sv
tb/sv/sparse_triplet_matvec_top_tb.sv
